/* design/rm2q_pkg.sv */
`default_nettype none
package rm2q_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = WORD_BITS - 2;
  // Root argument and trace: three words plus one, with sign.
  localparam int ARG_BITS  = WORD_BITS + 2;
  // Off-diagonal pair sums and differences.
  localparam int PAIR_BITS = WORD_BITS + 1;
  localparam int ROOT_BITS = FRAC_BITS + 1;
  localparam int REM_BITS  = WORD_BITS + 1;
  localparam int SQ_STEPS  = ROOT_BITS;
  localparam int DIV_STEPS = WORD_BITS - 1;
  localparam int LANES     = 3;

  localparam logic [ARG_BITS-1:0]  ONE_FIX = ARG_BITS'(1) << FRAC_BITS;
  localparam logic [WORD_BITS-1:0] MAX_POS = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] MIN_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    COMP_X,
    COMP_Y,
    COMP_Z,
    COMP_W
  } comp_e;

  // Classified item passed from the front to the back.
  typedef struct packed {
    comp_e                             sel;
    logic                              degen;
    logic [ARG_BITS-1:0]               arg;
    logic [LANES-1:0][PAIR_BITS-1:0]   pair;
  } item_t;

  typedef struct packed {
    logic [REM_BITS-1:0]  rem;
    logic [ROOT_BITS-1:0] root;
  } root_acc_t;

  typedef struct packed {
    comp_e                             sel;
    logic                              degen;
    logic [ARG_BITS-1:0]               arg;
    logic [REM_BITS-1:0]               rem;
    logic [ROOT_BITS-1:0]              root;
    logic [LANES-1:0][PAIR_BITS-1:0]   pair;
  } sq_t;

  typedef struct packed {
    logic                 neg;
    logic                 ovf;
    logic                 lsb;
    logic [REM_BITS-1:0]  rem;
    logic [DIV_STEPS-1:0] q;
  } lane_t;

  typedef struct packed {
    comp_e                 sel;
    logic                  degen;
    logic [ROOT_BITS-1:0]  root;
    logic [REM_BITS-1:0]   d;
    lane_t [LANES-1:0]     lane;
  } dv_t;

  // One digit of a restoring square root.
  function automatic root_acc_t sqrt_step(input logic [REM_BITS-1:0] rem,
                                          input logic [ROOT_BITS-1:0] root,
                                          input logic [1:0] bits);
    logic [REM_BITS+1:0] cur;
    logic [REM_BITS+1:0] trial;
    root_acc_t           r;
    cur   = {rem, bits};
    trial = {2'b00, root, 2'b01};
    if (cur >= trial) begin
      r.rem  = REM_BITS'(cur - trial);
      r.root = {root[ROOT_BITS-2:0], 1'b1};
    end else begin
      r.rem  = REM_BITS'(cur);
      r.root = {root[ROOT_BITS-2:0], 1'b0};
    end
    return r;
  endfunction

  // One quotient bit of a restoring division.
  function automatic lane_t div_step(input lane_t l, input logic [REM_BITS-1:0] d,
                                     input logic b);
    logic [REM_BITS:0] cur;
    lane_t             r;
    r   = l;
    cur = {l.rem, b};
    if (cur >= {1'b0, d}) begin
      r.rem = REM_BITS'(cur - {1'b0, d});
      r.q   = {l.q[DIV_STEPS-2:0], 1'b1};
    end else begin
      r.rem = REM_BITS'(cur);
      r.q   = {l.q[DIV_STEPS-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* design/rm2q_front.sv */
`default_nettype none
module rm2q_front
  import rm2q_pkg::*;
(
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic signed [WORD_BITS-1:0] r00_i,
  input  wire logic signed [WORD_BITS-1:0] r10_i,
  input  wire logic signed [WORD_BITS-1:0] r20_i,
  input  wire logic signed [WORD_BITS-1:0] r01_i,
  input  wire logic signed [WORD_BITS-1:0] r11_i,
  input  wire logic signed [WORD_BITS-1:0] r21_i,
  input  wire logic signed [WORD_BITS-1:0] r02_i,
  input  wire logic signed [WORD_BITS-1:0] r12_i,
  input  wire logic signed [WORD_BITS-1:0] r22_i,
  input  wire logic                        q_full_i,
  output logic                             push_o,
  output item_t                            item_o
);

  logic signed [ARG_BITS-1:0]  e00, e11, e22, one;
  logic signed [ARG_BITS-1:0]  arg_w, arg_x, arg_y, arg_z, arg_sel;
  logic signed [PAIR_BITS-1:0] s10, d21, s02, d02, s21, d10;
  item_t                       item_d, item_q;
  logic                        valid_q, load;

  assign e00 = ARG_BITS'(r00_i);
  assign e11 = ARG_BITS'(r11_i);
  assign e22 = ARG_BITS'(r22_i);
  assign one = $signed(ONE_FIX);

  assign arg_w = one + e00 + e11 + e22;
  assign arg_x = one + e00 - e11 - e22;
  assign arg_y = one + e11 - e00 - e22;
  assign arg_z = one + e22 - e00 - e11;

  assign s10 = PAIR_BITS'(r10_i) + PAIR_BITS'(r01_i);
  assign d10 = PAIR_BITS'(r10_i) - PAIR_BITS'(r01_i);
  assign s02 = PAIR_BITS'(r02_i) + PAIR_BITS'(r20_i);
  assign d02 = PAIR_BITS'(r02_i) - PAIR_BITS'(r20_i);
  assign s21 = PAIR_BITS'(r21_i) + PAIR_BITS'(r12_i);
  assign d21 = PAIR_BITS'(r21_i) - PAIR_BITS'(r12_i);

  // Lanes hold the three non-root components in ascending order.
  always_comb begin
    item_d = '0;
    priority if (arg_w > one) begin
      item_d.sel  = COMP_W;
      arg_sel     = arg_w;
      item_d.pair = {d10, d02, d21};
    end else if (r00_i > r11_i && r00_i > r22_i) begin
      item_d.sel  = COMP_X;
      arg_sel     = arg_x;
      item_d.pair = {d21, s02, s10};
    end else if (r11_i > r22_i) begin
      item_d.sel  = COMP_Y;
      arg_sel     = arg_y;
      item_d.pair = {d02, s21, s10};
    end else begin
      item_d.sel  = COMP_Z;
      arg_sel     = arg_z;
      item_d.pair = {d10, s21, s02};
    end
    item_d.arg   = arg_sel;
    item_d.degen = arg_sel[ARG_BITS-1] || (arg_sel == '0);
  end

  assign push_o     = valid_q && !q_full_i;
  assign load       = !valid_q || push_o;
  assign in_stall_o = !load;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      item_q <= item_d;
    end
  end

endmodule
`default_nettype wire

/* design/rm2q_queue.sv */
`default_nettype none
module rm2q_queue
  import rm2q_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  item_t      item_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       valid_o,
  output item_t      item_o
);

  item_t       mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;

  assign full_o  = cnt_q[1];
  assign valid_o = cnt_q != 2'd0;
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

/* design/rm2q_back.sv */
`default_nettype none
module rm2q_back
  import rm2q_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         q_valid_i,
  input  item_t             item_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic [WORD_BITS-1:0] quat_x_o,
  output logic [WORD_BITS-1:0] quat_y_o,
  output logic [WORD_BITS-1:0] quat_z_o,
  output logic [WORD_BITS-1:0] quat_w_o,
  output logic              degenerate_o
);

  logic                 en;
  sq_t                  sq_q [SQ_STEPS+1];
  sq_t                  sq_d [SQ_STEPS+1];
  logic [SQ_STEPS:0]    sv_q;
  dv_t                  dv_q [DIV_STEPS+1];
  dv_t                  dv_d [DIV_STEPS+1];
  logic [DIV_STEPS:0]   dvv_q;
  logic                 out_valid_q;
  logic [3:0][WORD_BITS-1:0] quat_d, quat_q;
  logic                 degen_q;
  logic [LANES-1:0][WORD_BITS-1:0] lane_val;

  // The whole back end moves in lockstep unless a finished item is held.
  assign en    = !out_valid_q || !out_stall_i;
  assign pop_o = en && q_valid_i;

  always_comb begin
    sq_d[0]      = '0;
    sq_d[0].sel  = item_i.sel;
    sq_d[0].degen = item_i.degen;
    sq_d[0].arg  = item_i.arg;
    sq_d[0].pair = item_i.pair;
  end

  for (genvar s = 0; s < SQ_STEPS; s++) begin : g_sq
    localparam int Lo = 2 * (SQ_STEPS - 1 - s) - (FRAC_BITS - 2);
    logic [1:0] bits;
    root_acc_t  acc;
    if (Lo >= 0) begin : g_hi
      assign bits = sq_q[s].arg[Lo+1:Lo];
    end else begin : g_lo
      assign bits = 2'b00;
    end
    assign acc = sqrt_step(sq_q[s].rem, sq_q[s].root, bits);
    always_comb begin
      sq_d[s+1]      = sq_q[s];
      sq_d[s+1].rem  = acc.rem;
      sq_d[s+1].root = acc.root;
    end
  end

  // Division setup: overflow is known before any quotient bit is formed.
  always_comb begin
    logic [PAIR_BITS-1:0] p, mag;
    dv_d[0]       = '0;
    dv_d[0].sel   = sq_q[SQ_STEPS].sel;
    dv_d[0].degen = sq_q[SQ_STEPS].degen;
    dv_d[0].root  = sq_q[SQ_STEPS].root;
    dv_d[0].d     = {sq_q[SQ_STEPS].root, 2'b00};
    for (int i = 0; i < LANES; i++) begin
      p   = sq_q[SQ_STEPS].pair[i];
      mag = p[PAIR_BITS-1] ? (~p + PAIR_BITS'(1)) : p;
      dv_d[0].lane[i].neg = p[PAIR_BITS-1];
      dv_d[0].lane[i].lsb = mag[0];
      dv_d[0].lane[i].rem = {1'b0, mag[PAIR_BITS-1:1]};
      dv_d[0].lane[i].ovf = {1'b0, mag[PAIR_BITS-1:1]} >= {sq_q[SQ_STEPS].root, 2'b00};
      dv_d[0].lane[i].q   = '0;
    end
  end

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_dv
    always_comb begin
      dv_d[s+1] = dv_q[s];
      for (int i = 0; i < LANES; i++) begin
        dv_d[s+1].lane[i] = div_step(dv_q[s].lane[i], dv_q[s].d,
                                     (s == 0) ? dv_q[s].lane[i].lsb : 1'b0);
      end
    end
  end

  always_comb begin
    lane_t l;
    for (int i = 0; i < LANES; i++) begin
      l = dv_q[DIV_STEPS].lane[i];
      if (l.ovf) begin
        lane_val[i] = l.neg ? MIN_NEG : MAX_POS;
      end else if (l.neg) begin
        lane_val[i] = ~{1'b0, l.q} + WORD_BITS'(1);
      end else begin
        lane_val[i] = {1'b0, l.q};
      end
    end
  end

  always_comb begin
    logic [1:0] sel;
    sel = dv_q[DIV_STEPS].sel;
    for (int j = 0; j < 4; j++) begin
      if (dv_q[DIV_STEPS].degen) begin
        quat_d[j] = '0;
      end else if (2'(j) == sel) begin
        quat_d[j] = WORD_BITS'(dv_q[DIV_STEPS].root);
      end else if (2'(j) < sel) begin
        quat_d[j] = lane_val[j];
      end else begin
        quat_d[j] = lane_val[j-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q        <= '0;
      dvv_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      sv_q        <= {sv_q[SQ_STEPS-1:0], pop_o};
      dvv_q       <= {dvv_q[DIV_STEPS-1:0], sv_q[SQ_STEPS]};
      out_valid_q <= dvv_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s <= SQ_STEPS; s++) begin
        sq_q[s] <= sq_d[s];
      end
      for (int s = 0; s <= DIV_STEPS; s++) begin
        dv_q[s] <= dv_d[s];
      end
      quat_q  <= quat_d;
      degen_q <= dv_q[DIV_STEPS].degen;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign quat_x_o     = quat_q[0];
  assign quat_y_o     = quat_q[1];
  assign quat_z_o     = quat_q[2];
  assign quat_w_o     = quat_q[3];
  assign degenerate_o = degen_q;

endmodule
`default_nettype wire

/* design/rotation_matrix_to_quaternion_unit.sv */
// Converts a 3x3 rotation matrix in signed Q2.30 to a unit quaternion in Q2.30
// by Shepperd's method. One item is accepted per clock and one result leaves
// per clock in steady state while out_stall_i is low; an item passes through
// a 31-stage square root pipeline followed by a setup stage and three
// parallel 31-stage division pipelines. A two-entry queue sits between
// the classifying front and the arithmetic back, and a held result stalls the
// whole back end. When the root argument is not positive the result is all
// zeros with degenerate_o set.
`default_nettype none
module rotation_matrix_to_quaternion_unit
  import rm2q_pkg::*;
(
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic signed [WORD_BITS-1:0] r00_i,
  input  wire logic signed [WORD_BITS-1:0] r10_i,
  input  wire logic signed [WORD_BITS-1:0] r20_i,
  input  wire logic signed [WORD_BITS-1:0] r01_i,
  input  wire logic signed [WORD_BITS-1:0] r11_i,
  input  wire logic signed [WORD_BITS-1:0] r21_i,
  input  wire logic signed [WORD_BITS-1:0] r02_i,
  input  wire logic signed [WORD_BITS-1:0] r12_i,
  input  wire logic signed [WORD_BITS-1:0] r22_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic signed [WORD_BITS-1:0]      quat_x_o,
  output logic signed [WORD_BITS-1:0]      quat_y_o,
  output logic signed [WORD_BITS-1:0]      quat_z_o,
  output logic signed [WORD_BITS-1:0]      quat_w_o,
  output logic                             degenerate_o
);

  item_t front_item, head_item;
  logic  push, full, head_valid, pop;

  rm2q_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .r00_i      (r00_i),
    .r10_i      (r10_i),
    .r20_i      (r20_i),
    .r01_i      (r01_i),
    .r11_i      (r11_i),
    .r21_i      (r21_i),
    .r02_i      (r02_i),
    .r12_i      (r12_i),
    .r22_i      (r22_i),
    .q_full_i   (full),
    .push_o     (push),
    .item_o     (front_item)
  );

  rm2q_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .item_o  (head_item)
  );

  rm2q_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (head_valid),
    .item_i       (head_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .quat_x_o     (quat_x_o),
    .quat_y_o     (quat_y_o),
    .quat_z_o     (quat_z_o),
    .quat_w_o     (quat_w_o),
    .degenerate_o (degenerate_o)
  );

endmodule
`default_nettype wire

/* design/rm2q_checker.sv */
`default_nettype none
module rm2q_checker
  import rm2q_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire logic [WORD_BITS-1:0] quat_x_o,
  input wire logic [WORD_BITS-1:0] quat_y_o,
  input wire logic [WORD_BITS-1:0] quat_z_o,
  input wire logic [WORD_BITS-1:0] quat_w_o,
  input wire logic                 degenerate_o
);

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(quat_x_o) &&
    $stable(quat_y_o) && $stable(quat_z_o) && $stable(quat_w_o) && $stable(degenerate_o))
    else $error("stalled result changed");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |->
    quat_x_o == '0 && quat_y_o == '0 && quat_z_o == '0 && quat_w_o == '0)
    else $error("degenerate result not zero");

  a_root_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !degenerate_o |->
    (!quat_x_o[WORD_BITS-1] && quat_x_o != '0) || (!quat_y_o[WORD_BITS-1] && quat_y_o != '0) ||
    (!quat_z_o[WORD_BITS-1] && quat_z_o != '0) || (!quat_w_o[WORD_BITS-1] && quat_w_o != '0))
    else $error("no positive root component");

endmodule

bind rotation_matrix_to_quaternion_unit rm2q_checker u_rm2q_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .quat_x_o     (quat_x_o),
  .quat_y_o     (quat_y_o),
  .quat_z_o     (quat_z_o),
  .quat_w_o     (quat_w_o),
  .degenerate_o (degenerate_o)
);
`default_nettype wire
